// ===== rtl/offset_dense_layer_fwd_bwd_core_macros.svh =====
// Assertion macros for the offset dense layer core.
`ifndef OFFSET_DENSE_LAYER_FWD_BWD_CORE_MACROS_SVH
`define OFFSET_DENSE_LAYER_FWD_BWD_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on clk, switched off while rst is high
`define ODFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on clk at every edge, reset included
`define ODFB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ODFB_ASSERT(lbl, prop, msg)
`define ODFB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/odfb_pkg.sv =====
// Shared constants, types and helpers of the offset dense layer core.
package odfb_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 16;
  localparam int PARAM_DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int PARAM_AW    = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
  localparam int IN_AW       = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OUT_AW      = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int ACC_W       = 53;

  // Configuration register indexes
  localparam logic [1:0] CFG_IN_COUNT   = 2'd0;
  localparam logic [1:0] CFG_OUT_COUNT  = 2'd1;
  localparam logic [1:0] CFG_LEARN_RATE = 2'd2;

  typedef enum logic [2:0] {
    K_PARAM = 3'd0,
    K_ACT   = 3'd1,
    K_GRAD  = 3'd2,
    K_FWD   = 3'd3,
    K_BWD   = 3'd4,
    K_READ  = 3'd5,
    K_CLEAR = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_S,
    ST_M1,
    ST_M2,
    ST_WR,
    ST_EMIT,
    ST_GRD,
    ST_GEMIT
  } state_t;

  // Per-cell control of the activation chain
  typedef struct packed {
    logic load;
    logic shift;
  } odfb_cell_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== rtl/offset_dense_layer_fwd_bwd_core.sv =====
// Forward: per output, steps RD, S, M1, M2 for each input, then the output's beat in EMIT; then idle again.
// Backward: per input, steps RD, S, M1, M2, WR for each output, then the input's beat in EMIT; then idle again.
// Read grads: GRD, then the beat from GEMIT; loads and clear are taken in idle and leave the core idle.
// One command at a time; stalls on the result side stretch the output beats.
// Reset (rst, synchronous): config to 16/16/1.0, gradient stores read as zero, idle.
`include "offset_dense_layer_fwd_bwd_core_macros.svh"
module offset_dense_layer_fwd_bwd_core
  import odfb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input items
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [2:0]          kind,
  input  logic [7:0]          index,
  input  logic signed [31:0]  value_a,
  input  logic signed [31:0]  value_b,
  // result items
  output logic                result_valid,
  input  logic                result_stall,
  output logic [7:0]          node_index,
  output logic signed [31:0]  node_value,
  output logic signed [31:0]  offset_grad,
  output logic signed [31:0]  weight_grad,
  output logic                last,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);

  state_t state, state_next;

  logic [4:0]  in_count;
  logic [4:0]  out_count;
  logic [30:0] learn_rate;

  logic [IN_AW-1:0]    ni_m1;
  logic [OUT_AW-1:0]   no_m1;
  logic [IN_AW-1:0]    i_cnt;
  logic [OUT_AW-1:0]   o_cnt;
  logic [PARAM_AW-1:0] p;
  logic                mode_fwd;
  logic [7:0]          rd_node;
  logic                rd_oor;

  logic signed [31:0]  offset_mem [PARAM_DEPTH];
  logic signed [31:0]  weight_mem [PARAM_DEPTH];
  logic signed [31:0]  og_mem [PARAM_DEPTH];
  logic signed [31:0]  wg_mem [PARAM_DEPTH];
  logic [PARAM_DEPTH-1:0] gvalid;
  logic signed [31:0]  out_grad [MAX_OUTPUTS];

  logic signed [31:0]  b_rd, w_rd, og_rd, wg_rd;
  logic                gv_rd;
  logic signed [31:0]  og_eff, wg_eff;

  logic signed [31:0]  x_head, x_r, g_r, s_r, w_r;
  logic signed [63:0]  prod_a, prod_b, u_a, u_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0]  lr_s;

  logic kind_cast_ok;
  kind_t item_kind;
  logic in_take, out_free, i_last, o_last, shift, emit_load, wr_grad, done;

  assign item_kind = kind_t'(kind);
  assign kind_cast_ok = 1'b1;
  assign in_take   = item_valid && !item_stall && kind_cast_ok;
  assign out_free  = !result_valid || !result_stall;
  assign i_last    = (i_cnt == ni_m1);
  assign o_last    = (o_cnt == no_m1);
  assign done      = mode_fwd ? o_last : i_last;
  assign cfg_ready = 1'b1;
  assign lr_s      = signed'({1'b0, learn_rate});

  // Clamped node counts, minus one
  always_comb begin
    if (in_count == 5'd0) begin
      ni_m1 = '0;
    end else if (32'(in_count) > MAX_INPUTS) begin
      ni_m1 = IN_AW'(MAX_INPUTS - 1);
    end else begin
      ni_m1 = IN_AW'(in_count - 5'd1);
    end
    if (out_count == 5'd0) begin
      no_m1 = '0;
    end else if (32'(out_count) > MAX_OUTPUTS) begin
      no_m1 = OUT_AW'(MAX_OUTPUTS - 1);
    end else begin
      no_m1 = OUT_AW'(out_count - 5'd1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count   <= 5'd16;
      out_count  <= 5'd16;
      learn_rate <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IN_COUNT:   in_count   <= cfg_data[4:0];
        CFG_OUT_COUNT:  out_count  <= cfg_data[4:0];
        CFG_LEARN_RATE: learn_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (item_kind)
            K_FWD, K_BWD: state_next = ST_RD;
            K_READ:       state_next = ST_GRD;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD:    state_next = ST_S;
      ST_S:     state_next = ST_M1;
      ST_M1:    state_next = ST_M2;
      ST_M2:    state_next = mode_fwd ? (i_last ? ST_EMIT : ST_RD) : ST_WR;
      ST_WR:    state_next = o_last ? ST_EMIT : ST_RD;
      ST_EMIT: begin
        if (out_free) begin
          state_next = done ? ST_IDLE : ST_RD;
        end
      end
      ST_GRD:   state_next = ST_GEMIT;
      ST_GEMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    item_stall = (state != ST_IDLE);
    shift      = (mode_fwd && state == ST_M2) || (!mode_fwd && state == ST_WR && o_last);
    emit_load  = (state == ST_EMIT || state == ST_GEMIT) && out_free;
    wr_grad    = (state == ST_WR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loop counters and parameter address
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_fwd <= 1'b0;
      i_cnt    <= '0;
      o_cnt    <= '0;
      p        <= '0;
      acc      <= '0;
      rd_node  <= '0;
      rd_oor   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            mode_fwd <= (item_kind == K_FWD);
            i_cnt    <= '0;
            o_cnt    <= '0;
            acc      <= '0;
            rd_node  <= index;
            rd_oor   <= ({1'b0, index} >= 9'(PARAM_DEPTH));
            p        <= (item_kind == K_READ) ? PARAM_AW'(index) : '0;
          end
        end
        ST_M2: begin
          acc <= acc + (mode_fwd ? ACC_W'(prod_a >>> 16) : ACC_W'(prod_b >>> 16));
          if (mode_fwd && !i_last) begin
            i_cnt <= i_cnt + 1'b1;
            p     <= p + 1'b1;
          end
        end
        ST_WR: begin
          if (!o_last) begin
            o_cnt <= o_cnt + 1'b1;
            p     <= PARAM_AW'(p + PARAM_AW'(ni_m1) + PARAM_AW'(1));
          end
        end
        ST_EMIT: begin
          if (out_free && !done) begin
            acc <= '0;
            if (mode_fwd) begin
              o_cnt <= o_cnt + 1'b1;
              i_cnt <= '0;
              p     <= p + 1'b1;
            end else begin
              i_cnt <= i_cnt + 1'b1;
              o_cnt <= '0;
              p     <= PARAM_AW'(i_cnt) + PARAM_AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Parameter stores: written by param beats, read at p
  always_ff @(posedge clk) begin
    if (in_take && item_kind == K_PARAM && ({1'b0, index} < 9'(PARAM_DEPTH))) begin
      offset_mem[PARAM_AW'(index)] <= value_a;
      weight_mem[PARAM_AW'(index)] <= value_b;
    end
    b_rd <= offset_mem[p];
    w_rd <= weight_mem[p];
  end

  // Gradient stores with per-entry valid bits (invalid reads as zero)
  always_ff @(posedge clk) begin
    if (wr_grad) begin
      wg_mem[p] <= sat32(64'(wg_eff) + 64'(sat32(u_a >>> 16)));
      og_mem[p] <= sat32(64'(og_eff) + 64'(sat32(u_b >>> 16)));
    end
    og_rd <= og_mem[p];
    wg_rd <= wg_mem[p];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= '0;
      gv_rd  <= 1'b0;
    end else begin
      if (in_take && item_kind == K_CLEAR) begin
        gvalid <= '0;
      end else if (wr_grad) begin
        gvalid[p] <= 1'b1;
      end
      gv_rd <= gvalid[p];
    end
  end

  assign og_eff = gv_rd ? og_rd : '0;
  assign wg_eff = gv_rd ? wg_rd : '0;

  // Output gradient registers
  always_ff @(posedge clk) begin
    if (in_take && item_kind == K_GRAD && (32'(index) < MAX_OUTPUTS)) begin
      out_grad[OUT_AW'(index)] <= value_a;
    end
  end

  // Activation ring
  odfb_act_chain u_chain (
    .clk        (clk),
    .load       (in_take && item_kind == K_ACT && (32'(index) < MAX_INPUTS)),
    .load_index (IN_AW'(index)),
    .load_value (value_a),
    .shift      (shift),
    .len_m1     (ni_m1),
    .head       (x_head)
  );

  // MAC datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_RD: begin
        x_r <= x_head;
        g_r <= out_grad[o_cnt];
      end
      ST_S: begin
        s_r <= sat32(64'(x_r) + 64'(b_rd));
        w_r <= w_rd;
      end
      ST_M1: begin
        prod_a <= s_r * (mode_fwd ? w_r : g_r);
        prod_b <= w_r * g_r;
      end
      ST_M2: begin
        u_a <= sat32(prod_a >>> 16) * lr_s;
        u_b <= sat32(prod_b >>> 16) * lr_s;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      if (state == ST_GEMIT) begin
        node_index  <= rd_node;
        node_value  <= '0;
        offset_grad <= rd_oor ? '0 : og_eff;
        weight_grad <= rd_oor ? '0 : wg_eff;
        last        <= 1'b1;
      end else begin
        node_index  <= mode_fwd ? 8'(o_cnt) : 8'(i_cnt);
        node_value  <= sat32(64'(acc));
        offset_grad <= '0;
        weight_grad <= '0;
        last        <= done;
      end
    end
  end

  // Checks
  `ODFB_ASSERT_RST(a_reset_idle, rst |=> (state == ST_IDLE && !result_valid), "reset not idle")
  `ODFB_ASSERT(a_fwd_start, (in_take && item_kind == K_FWD) |=> (state == ST_RD && acc == 0), "fwd start")
  `ODFB_ASSERT(a_emit_hold, (state == ST_EMIT && result_valid && result_stall) |=> state == ST_EMIT, "emit lost")

endmodule

// ===== rtl/odfb_cell.sv =====
// One activation cell: holds a value, loads it or takes the neighbour's.
module odfb_cell
  import odfb_pkg::*;
(
  input  logic                  clk,
  input  odfb_cell_ctl_t        ctl,
  input  logic signed [31:0]    load_value,
  input  logic signed [31:0]    next_value,
  output logic signed [31:0]    value
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= load_value;
    end else if (ctl.shift) begin
      value <= next_value;
    end
  end

endmodule

// ===== rtl/odfb_act_chain.sv =====
// Ring of activation cells; cell 0 presents the current input activation.
module odfb_act_chain
  import odfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  load,
  input  logic [IN_AW-1:0]      load_index,
  input  logic signed [31:0]    load_value,
  input  logic                  shift,
  input  logic [IN_AW-1:0]      len_m1,
  output logic signed [31:0]    head
);

  logic signed [31:0] cval [MAX_INPUTS];

  assign head = cval[0];

  for (genvar k = 0; k < MAX_INPUTS; k++) begin : g_cell
    odfb_cell_ctl_t     ctl;
    logic signed [31:0] nb;

    // last cell in use wraps round to the head
    if (k == MAX_INPUTS - 1) begin : g_end
      assign nb = cval[0];
    end else begin : g_mid
      assign nb = (IN_AW'(k) == len_m1) ? cval[0] : cval[k+1];
    end

    assign ctl.load  = load && (load_index == IN_AW'(k));
    assign ctl.shift = shift && (IN_AW'(k) <= len_m1);

    odfb_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .load_value (load_value),
      .next_value (nb),
      .value      (cval[k])
    );
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the offset dense layer core: directed and random beats.
`timescale 1ns / 100ps

module tb_top;
  import odfb_pkg::*;

  localparam logic [2:0] K_UNUSED = 3'd7;
  localparam int         IDLE_PAUSE = 40;

  // Expected result beat
  typedef struct {
    logic [7:0] idx;
    int         val;
    int         ogr;
    int         wgr;
    bit         lst;
  } layer_beat_t;

  // Shadow of the layer state; predicts result beats from accepted input beats
  class layer_scoreboard;
    int unsigned in_cfg, out_cfg, rate;
    int offs[PARAM_DEPTH], wts[PARAM_DEPTH], acts[MAX_INPUTS], ograds[MAX_OUTPUTS];
    int off_acc[PARAM_DEPTH], wt_acc[PARAM_DEPTH];
    layer_beat_t due[$];

    function new();
      in_cfg = 16; out_cfg = 16; rate = 65536;
      foreach (off_acc[p]) begin
        off_acc[p] = 0; wt_acc[p] = 0;
        offs[p] = 0; wts[p] = 0;
      end
      foreach (acts[i]) acts[i] = 0;
      foreach (ograds[o]) ograds[o] = 0;
    endfunction

    function longint fl16(longint v);
      return v >>> 16;
    endfunction

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function int unsigned clampc(int unsigned v, int unsigned mx);
      if (v == 0) return 1;
      return (v > mx) ? mx : v;
    endfunction

    function int scaled(longint prod);
      longint t;
      t = sat(fl16(prod));
      return sat(fl16(t * longint'(rate)));
    endfunction

    function void set_reg(logic [1:0] ri, logic [30:0] d);
      case (ri)
        CFG_IN_COUNT:   in_cfg = d[4:0];
        CFG_OUT_COUNT:  out_cfg = d[4:0];
        CFG_LEARN_RATE: rate = d;
        default: ;
      endcase
    endfunction

    function void push(logic [7:0] i, int v, int og, int wg, bit l);
      layer_beat_t b;
      b.idx = i; b.val = v; b.ogr = og; b.wgr = wg; b.lst = l;
      due.push_back(b);
    endfunction

    function void note_input(logic [2:0] k, logic [7:0] i, int a, int b);
      int unsigned ni, no, p;
      longint acc, s, g, wg;
      ni = clampc(in_cfg, MAX_INPUTS);
      no = clampc(out_cfg, MAX_OUTPUTS);
      case (k)
        K_PARAM: begin
          offs[i] = a; wts[i] = b;
        end
        K_ACT:  if (i < MAX_INPUTS) acts[i] = a;
        K_GRAD: if (i < MAX_OUTPUTS) ograds[i] = a;
        K_FWD: begin
          for (int o = 0; o < no; o++) begin
            acc = 0;
            for (int n = 0; n < ni; n++) begin
              p = o * ni + n;
              s = sat(longint'(acts[n]) + offs[p]);
              acc += fl16(s * wts[p]);
            end
            push(8'(o), sat(acc), 0, 0, o + 1 == no);
          end
        end
        K_BWD: begin
          for (int n = 0; n < ni; n++) begin
            acc = 0;
            for (int o = 0; o < no; o++) begin
              p = o * ni + n;
              g = ograds[o];
              s = sat(longint'(acts[n]) + offs[p]);
              wg = longint'(wts[p]) * g;
              wt_acc[p] = sat(longint'(wt_acc[p]) + scaled(s * g));
              off_acc[p] = sat(longint'(off_acc[p]) + scaled(wg));
              acc += fl16(wg);
            end
            push(8'(n), sat(acc), 0, 0, n + 1 == ni);
          end
        end
        K_READ: push(i, 0, off_acc[i], wt_acc[i], 1);
        K_CLEAR: begin
          foreach (off_acc[q]) begin
            off_acc[q] = 0; wt_acc[q] = 0;
          end
        end
        default: ;
      endcase
    endfunction

    // Compares one result beat with the oldest expectation; empty msg when it matches
    function void check_result(logic [7:0] i, int v, int og, int wg, bit l,
                               output string msg);
      layer_beat_t e;
      msg = "";
      if (due.size() == 0) begin
        $sformat(msg, "result beat idx %0d with nothing expected", i);
        return;
      end
      e = due.pop_front();
      if (i !== e.idx || v !== e.val || og !== e.ogr || wg !== e.wgr || l !== e.lst)
        $sformat(msg, "got idx %0d val %h og %h wg %h last %b, want %0d %h %h %h %b",
                 i, v, og, wg, l, e.idx, e.val, e.ogr, e.wgr, e.lst);
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic [2:0]        kind = '0;
  logic [7:0]        index = '0;
  logic signed [31:0] value_a = '0;
  logic signed [31:0] value_b = '0;
  logic              result_valid;
  logic              result_stall = 1'b1;
  logic [7:0]        node_index;
  logic signed [31:0] node_value, offset_grad, weight_grad;
  logic              last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [30:0]       cfg_data = '0;

  layer_scoreboard sb = new();
  int  errors = 0;
  int  send_gap = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  bit  run_done = 1'b0;

  offset_dense_layer_fwd_bwd_core u_dut (.*);

  always #5 clk = ~clk;

  task report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Input beat: idle gap, offer, wait for acceptance
  task send_item(input logic [2:0] k, input logic [7:0] i, input int a, input int b);
    repeat (send_gap) @(posedge clk);
    item_valid <= 1'b1;
    kind <= k; index <= i; value_a <= a; value_b <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_input(k, i, a, b);
    send_gap = no_idle ? 0 : $urandom_range(0, 7);
    if (send_gap > 0) item_valid <= 1'b0;
  endtask

  task stop_items();
    if (send_gap == 0) item_valid <= 1'b0;
    send_gap = 1;
  endtask

  // Register write beat; the caller drops cfg_valid after the last one
  task write_reg(input logic [1:0] ri, input logic [30:0] d);
    cfg_valid <= 1'b1; cfg_index <= ri; cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(ri, d);
  endtask

  task wait_idle();
    stop_items();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task set_layer(input logic [4:0] ni, input logic [4:0] no, input logic [30:0] lr);
    wait_idle();
    write_reg(CFG_IN_COUNT, 31'(ni));
    write_reg(CFG_OUT_COUNT, 31'(no));
    write_reg(CFG_LEARN_RATE, lr);
    cfg_valid <= 1'b0;
  endtask

  function int rand_q();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 'h3ffff) - 'h20000;
      default: return $urandom();
    endcase
  endfunction

  // Random beat mix, mostly loads with commands spread through
  task random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      send_item(K_PARAM, 8'($urandom_range(0, 255)), rand_q(), rand_q());
    else if (r < 45) send_item(K_ACT, 8'($urandom_range(0, 19)), rand_q(), $urandom());
    else if (r < 60) send_item(K_GRAD, 8'($urandom_range(0, 19)), rand_q(), $urandom());
    else if (r < 70) send_item(K_FWD, 8'($urandom()), $urandom(), $urandom());
    else if (r < 79) send_item(K_BWD, 8'($urandom()), $urandom(), $urandom());
    else if (r < 93) send_item(K_READ, 8'($urandom_range(0, 255)), $urandom(), $urandom());
    else if (r < 96) send_item(K_CLEAR, 8'($urandom()), $urandom(), $urandom());
    else             send_item(K_UNUSED, 8'($urandom()), $urandom(), $urandom());
  endtask

  // Result side: random stall per beat, one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        int g;
        g = no_idle ? 0 : $urandom_range(0, 7);
        if (g > 0) begin
          result_stall <= 1'b1;
          repeat (g) @(posedge clk);
        end
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // Result checker
  always @(posedge clk) begin
    string msg;
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(node_index, node_value, offset_grad, weight_grad, last, msg);
      if (msg != "") report(msg);
    end
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every parameter, activation and output gradient entry so no command touches an unwritten one
    no_idle = 1'b1;
    for (int p = 0; p < PARAM_DEPTH; p++) send_item(K_PARAM, 8'(p), rand_q(), rand_q());
    for (int n = 0; n < MAX_INPUTS; n++) send_item(K_ACT, 8'(n), rand_q(), 0);
    for (int o = 0; o < MAX_OUTPUTS; o++) send_item(K_GRAD, 8'(o), rand_q(), 0);
    no_idle = 1'b0;

    // Directed: reset setting first, then extremes and corner cases
    send_item(K_READ, 8'd0, 0, 0);
    send_item(K_PARAM, 8'd0, 32'sh7fffffff, 32'sh7fffffff);
    send_item(K_PARAM, 8'd255, 32'sh80000000, 32'sh80000000);
    send_item(K_ACT, 8'd0, 32'sh7fffffff, 0);
    send_item(K_ACT, 8'd15, 32'sh80000000, 0);
    send_item(K_ACT, 8'd200, 32'sh12345678, 0);
    send_item(K_GRAD, 8'd0, 32'sh80000000, 0);
    send_item(K_GRAD, 8'd15, 32'sh7fffffff, 0);
    send_item(K_GRAD, 8'd255, 32'sh00010000, 0);
    send_item(K_UNUSED, 8'hff, -1, -1);
    send_item(K_FWD, 8'd0, 0, 0);
    send_item(K_BWD, 8'd0, 0, 0);
    send_item(K_READ, 8'd0, 0, 0);
    send_item(K_READ, 8'd255, 0, 0);
    send_item(K_CLEAR, 8'd0, 0, 0);
    send_item(K_READ, 8'd255, 0, 0);

    // Zero counts act as one, top rate
    set_layer(5'd0, 5'd0, 31'h7fffffff);
    send_item(K_BWD, 8'd0, 0, 0);
    send_item(K_BWD, 8'd0, 0, 0);
    send_item(K_READ, 8'd0, 0, 0);
    send_item(K_FWD, 8'd0, 0, 0);

    // Over-range counts clamp, zero rate for the first
    set_layer(5'd31, 5'd1, 31'd0);
    send_item(K_BWD, 8'd0, 0, 0);
    send_item(K_READ, 8'd3, 0, 0);
    set_layer(5'd1, 5'd31, 31'd65536);
    send_item(K_FWD, 8'd0, 0, 0);

    // Random phases; the first one holds the result side off for a long stretch
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_layer(5'd16, 5'd16, 31'($urandom_range(0, 'h7fffffff)));
      else set_layer(5'($urandom_range(0, 6)), 5'($urandom_range(0, 6)),
                     31'($urandom_range(0, 3) == 0 ? $urandom()
                                                   : $urandom_range(0, 'h40000)));
      no_idle = (ph == 2);
      if (ph == 0) begin
        hold_req = 1'b1;
        send_item(K_FWD, 8'd0, 0, 0);
        send_item(K_BWD, 8'd0, 0, 0);
        send_item(K_READ, 8'($urandom()), 0, 0);
      end
      for (int n = 0; n < (ph == 5 ? 6 : 8); n++) random_item();
    end

    wait_idle();
    if (sb.pending() != 0) report("expected beats left over");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
